// ===== rtl/efps_pkg.sv =====
`default_nettype none
package efps_pkg;
  localparam int NUM_Q = 9;
  localparam int Q_DEPTH = 3;
  localparam int Q_R = 4;
  localparam int Q_U = 7;
  localparam int Q_V = 8;
  localparam int NUM_SLOTS = 27;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_PIXEL = 2'd1;
  localparam logic [1:0] REQ_ROW = 2'd2;

  localparam logic [2:0] CFG_TEX_WIDTH = 3'd0;
  localparam logic [2:0] CFG_TEX_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_TEXTURED = 3'd2;
  localparam logic [2:0] CFG_COLOR_VARYING = 3'd3;
  localparam logic [2:0] CFG_CONST_COLOR = 3'd4;
  localparam logic [2:0] CFG_DEPTH_ENABLE = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic load;      // store setup word of the captured request
    logic row;       // advance row accumulators
    logic eval;      // compute pixel result and start texel reduction
    logic step;      // add x steps to pixel accumulators
  } efps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tex_done;  // texel reduction finished
  } efps_sts_t;

  function automatic logic [7:0] clamp8(input logic [31:0] acc);
    logic signed [23:0] c;
    c = $signed(acc[31:8]);
    if (c < 0) return 8'd0;
    if (c > 24'sd255) return 8'd255;
    return c[7:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/efps_ctrl.sv =====
`default_nettype none
module efps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire logic [1:0]        in_type,
  output logic                   busy,
  output efps_pkg::efps_cmd_t    cmd,
  input  wire efps_pkg::efps_sts_t sts,
  output logic                   res_valid,
  input  wire logic              res_ready
);
  import efps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DO   = 4'b0010,
    S_TEX  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [1:0] req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      req <= REQ_LOAD;
    end else begin
      state <= state_next;
      if (in_fire) req <= in_type;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: if (in_fire) state_next = S_DO;
      S_DO: begin
        case (req)
          REQ_LOAD: begin cmd.load = 1'b1; state_next = S_IDLE; end
          REQ_ROW: begin cmd.row = 1'b1; state_next = S_IDLE; end
          REQ_PIXEL: begin cmd.eval = 1'b1; state_next = S_TEX; end
          default: state_next = S_IDLE;
        endcase
      end
      S_TEX: if (sts.tex_done) begin
        cmd.step = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign res_valid = (state == S_OUT);

`ifndef SYNTHESIS
  a_out_from_tex: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_TEX && sts.tex_done))
    else $error("result without texel completion");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped under stall");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_DO)
    else $error("accept did not start work");
`endif
endmodule
`default_nettype wire

// ===== rtl/efps_dp.sv =====
`default_nettype none
module efps_dp #(
  parameter int MAX_TEX_DIM = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire logic [4:0]        in_index,
  input  wire logic [31:0]       in_value,
  input  wire logic [15:0]       in_sdepth,
  input  wire efps_pkg::efps_cmd_t cmd,
  output efps_pkg::efps_sts_t    sts,
  input  wire logic              cfg_fire,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_value,
  output logic [73:0]            res
);
  import efps_pkg::*;

  localparam int DW = $clog2(MAX_TEX_DIM + 1);
  localparam int PW = 32 + DW;
  localparam int TW = PW - 16;

  logic [8:0]  tex_width, tex_height;
  logic        textured, color_varying, depth_enable;
  logic [23:0] const_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width <= 9'd1;
      tex_height <= 9'd1;
      textured <= 1'b0;
      color_varying <= 1'b0;
      const_color <= '0;
      depth_enable <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_TEX_WIDTH: tex_width <= cfg_value[8:0];
        CFG_TEX_HEIGHT: tex_height <= cfg_value[8:0];
        CFG_TEXTURED: textured <= cfg_value[0];
        CFG_COLOR_VARYING: color_varying <= cfg_value[0];
        CFG_CONST_COLOR: const_color <= cfg_value[23:0];
        CFG_DEPTH_ENABLE: depth_enable <= cfg_value[0];
        default: ;
      endcase
    end
  end

  logic [4:0]  idx;
  logic [31:0] val;
  logic [15:0] sdepth;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx <= in_index;
      val <= in_value;
      sdepth <= in_sdepth;
    end
  end

  logic [31:0] xs [NUM_Q];
  logic [31:0] ys [NUM_Q];
  logic [31:0] racc [NUM_Q];
  logic [31:0] pacc [NUM_Q];

  // slot to quantity / kind: idx * 11 / 32 equals idx / 3 for all 5-bit slots
  logic [3:0] q_sel;
  logic [1:0] k_sel;
  logic [8:0] q_mul;
  logic [4:0] q3;
  always_comb begin
    q_mul = 9'(idx) * 9'd11;
    q_sel = q_mul[8:5];
    q3 = {1'b0, q_sel} * 5'd3;
    k_sel = 2'(idx - q3);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_Q; i++) begin
      if (cmd.load && idx < 5'(NUM_SLOTS) && q_sel == 4'(i)) begin
        case (k_sel)
          2'd0: begin racc[i] <= val; pacc[i] <= val; end
          2'd1: xs[i] <= val;
          default: ys[i] <= val;
        endcase
      end else if (cmd.row) begin
        racc[i] <= racc[i] + ys[i];
        pacc[i] <= racc[i] + ys[i];
      end else if (cmd.step) begin
        pacc[i] <= pacc[i] + xs[i];
      end
    end
  end

  function automatic logic [DW-1:0] eff_dim(input logic [8:0] d);
    if (d == 9'd0) return DW'(1);
    if (32'(d) > 32'(MAX_TEX_DIM)) return DW'(MAX_TEX_DIM);
    return DW'(d);
  endfunction

  // products: one 32xDW multiply per axis at eval
  logic signed [PW-1:0] pu, pv;
  logic [DW-1:0] dim_u, dim_v;
  logic busy_u, busy_v;

  // fixed result fields captured at eval; wr is derived from them combinationally
  logic cov, wr;
  logic [15:0] d16;
  logic [23:0] col;

  logic signed [23:0] dd;
  assign dd = $signed(pacc[Q_DEPTH][31:8]);

  // restoring reduction: shift-subtract of floor(p/65536) modulo dim
  logic [4:0] bitcnt;
  logic signed [TW-1:0] tu, tv;
  logic [DW:0] remu, remv;
  logic [DW:0] su, sv;

  always_comb begin
    su = {remu[DW-1:0], tu[TW-1]};
    sv = {remv[DW-1:0], tv[TW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_u <= 1'b0;
      bitcnt <= '0;
    end else if (cmd.eval) begin
      busy_u <= 1'b1;
      bitcnt <= 5'(TW);
    end else if (busy_u) begin
      if (bitcnt == 5'd0) busy_u <= 1'b0;
      else bitcnt <= bitcnt - 5'd1;
    end
  end
  assign busy_v = busy_u;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      dim_u <= eff_dim(tex_width);
      dim_v <= eff_dim(tex_height);
      pu <= $signed(pacc[Q_U]) * $signed({1'b0, eff_dim(tex_width)});
      pv <= $signed(pacc[Q_V]) * $signed({1'b0, eff_dim(tex_height)});
      cov <= ~(pacc[0][31] | pacc[1][31] | pacc[2][31]);
      d16 <= (dd < 0) ? 16'd0 : ((dd > 24'sd65535) ? 16'hffff : dd[15:0]);
      col <= color_varying ? {clamp8(pacc[Q_R+2]), clamp8(pacc[Q_R+1]), clamp8(pacc[Q_R])}
                           : const_color;
    end else if (busy_u) begin
      if (bitcnt == 5'(TW)) begin
        // sign bit weighs -2^(TW-1): seed remainder with -1 mod dim, then the
        // remaining TW-1 bits follow one per cycle
        tu <= {pu[PW-2:16], 1'b0};
        tv <= {pv[PW-2:16], 1'b0};
        remu <= pu[PW-1] ? {1'b0, dim_u - DW'(1)} : '0;
        remv <= pv[PW-1] ? {1'b0, dim_v - DW'(1)} : '0;
      end else begin
        tu <= tu <<< 1;
        tv <= tv <<< 1;
        remu <= (su >= {1'b0, dim_u}) ? su - {1'b0, dim_u} : su;
        remv <= (sv >= {1'b0, dim_v}) ? sv - {1'b0, dim_v} : sv;
      end
    end
  end

  assign sts.tex_done = busy_u && bitcnt == 5'd0;
  assign wr = cov && (!depth_enable || d16 < sdepth);

  always_ff @(posedge clk) begin
    if (sts.tex_done) begin
      res <= {textured ? pv[15:8] : 8'd0, textured ? pu[15:8] : 8'd0,
              textured ? remv[7:0] : 8'd0, textured ? remu[7:0] : 8'd0,
              col, d16, wr, cov};
    end
  end

`ifndef SYNTHESIS
  a_rem_u: assert property (@(posedge clk) disable iff (rst)
    busy_u && bitcnt != 5'(TW) |-> remu < {1'b0, dim_u})
    else $error("remainder out of range");
  a_rem_v: assert property (@(posedge clk) disable iff (rst)
    busy_u && bitcnt != 5'(TW) |-> remv < {1'b0, dim_v})
    else $error("remainder out of range");
  a_lanes: assert property (@(posedge clk) disable iff (rst) busy_u == busy_v)
    else $error("lanes out of step");
`endif
endmodule
`default_nettype wire

// ===== rtl/edge_function_pixel_stepper_unit.sv =====
`default_nettype none
// Half-space rasterizer inner loop.
// s_axis: one request per item; tdata = coef_index[4:0], coef_value[36:5],
//   stored_depth[52:37]; tuser = req_type. Load (0) stores a setup word,
//   pixel (1) yields one result, next row (2) advances row accumulators.
// m_axis: tdata = covered, write_pixel, pixel_depth[17:2], pixel_color[41:18],
//   texel_col[49:42], texel_row[57:50], frac_col[65:58], frac_row[73:66].
// cfg: cfg_valid/cfg_ready, cfg_index selects the register, cfg_data value.
// One request is handled at a time. Load and next row finish in the S_DO state.
// A pixel computes its products and result fields in S_DO, then waits in S_TEX
// for the shift-subtract texel modulo unit (one product bit per cycle per axis);
// the result then sits in the output register with m_axis_tvalid high until
// m_axis_tready, and the next request can be accepted once it is taken.
// While the result waits, s_axis_tready stays low.
// Reset restores tex size 1, all other config registers 0; setup words and
// accumulators are undefined until loaded.
module edge_function_pixel_stepper_unit #(
  parameter int MAX_TEX_DIM = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // coef_index, coef_value, stored_depth
  input  wire logic [1:0]  s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,  // covered, write_pixel, pixel_depth,
                                          // pixel_color, texel_col, texel_row,
                                          // frac_col, frac_row
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import efps_pkg::*;

  efps_cmd_t cmd;
  efps_sts_t sts;
  logic busy, in_fire;
  logic [73:0] res;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  efps_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_type(s_axis_tuser), .busy, .cmd, .sts,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready)
  );

  efps_dp #(.MAX_TEX_DIM(MAX_TEX_DIM)) u_dp (
    .clk, .rst, .in_fire,
    .in_index(s_axis_tdata[4:0]), .in_value(s_axis_tdata[36:5]),
    .in_sdepth(s_axis_tdata[52:37]), .cmd, .sts,
    .cfg_fire(cfg_valid && cfg_ready), .cfg_index, .cfg_value(cfg_data), .res
  );

  assign m_axis_tdata = {6'd0, res};
endmodule
`default_nettype wire
